### rtl/core/ngvl_pkg.sv
// ----------------------------------------------------------------------------
// ngvl_pkg
// Shared types, constants and the direction-table generator for the
// normal grid vertex light core.
// ----------------------------------------------------------------------------
package ngvl_pkg;

    localparam int unsigned GRID_PITCH_DEF = 64;
    localparam int unsigned GRID_YAW_DEF   = 64;
    localparam int unsigned QUEUE_DEPTH    = 4;

    localparam int unsigned CORDIC_STEPS   = 16;
    localparam int unsigned CORDIC_IDX_W   = $clog2(CORDIC_STEPS);
    localparam int unsigned SQRT_STEPS     = 24;

    localparam int unsigned CFG_IDX_W      = 2;
    localparam int unsigned CFG_DATA_W     = 9;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_FLOOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_CEILING = 2'd1;
    localparam logic [CFG_DATA_W-1:0] LIGHT_FLOOR_RST   = 9'd50;
    localparam logic [CFG_DATA_W-1:0] LIGHT_CEILING_RST = 9'd256;

    localparam int DEG90_Q7  = 11520;
    localparam int DEG270_Q7 = 34560;
    localparam int DEG360_Q7 = 46080;
    localparam longint DEG180_Q16 = 180 * 65536;
    localparam longint INV_GAIN_Q16 = 39797;

    // reciprocal of 360 degrees (Q7) for the grid index divide
    localparam int unsigned RECIP_SHIFT = 40;
    localparam int unsigned RECIP_W     = 25;
    localparam logic [RECIP_W-1:0] RECIP_360 = 25'((64'd1 << RECIP_SHIFT) / 64'd46080);

    localparam longint ATAN_DEG_Q16 [CORDIC_STEPS] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };

    typedef logic signed [15:0] t_s16;
    typedef logic signed [16:0] t_s17;
    typedef logic signed [26:0] t_ang;

    typedef struct packed {
        t_s16 c;
        t_s16 s;
    } t_sc;

    typedef struct packed {
        logic        zero;
        t_s16        nx;
        t_s16        ny;
        t_s16        nz;
        t_s16        dx;
        t_s16        dy;
        t_s16        dz;
        t_s17        po;
        t_s17        yo;
        logic [30:0] sqx;
        logic [30:0] sqy;
    } t_front_item;

    // cos/sin of a whole-degree angle, Q14, built at elaboration
    function automatic t_sc sin_cos_deg(int deg);
        longint a;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint c;
        longint s;
        logic   flip;
        int     i;
        t_sc    r;
        a    = deg;
        flip = 1'b0;
        x    = INV_GAIN_Q16 * 256;
        y    = 0;
        if (a > 180) a = a - 360;
        if (a > 90) begin
            a    = a - 180;
            flip = 1'b1;
        end else if (a < -90) begin
            a    = a + 180;
            flip = 1'b1;
        end
        z = a * 65536;
        for (i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG_Q16[i];
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG_Q16[i];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (flip) begin
            c = -c;
            s = -s;
        end
        r.c = 16'(c);
        r.s = 16'(s);
        return r;
    endfunction

endpackage

### rtl/core/normal_grid_vertex_light_core.sv
// ----------------------------------------------------------------------------
// normal_grid_vertex_light_core
// Per-vertex light factor from a normal quantized onto a direction grid.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle; the back pipeline stalls as a whole only
// while a result waits and pop is low, and a 4-entry queue holds new beats.
// Most of the depth comes from the 24-step square root followed by the 16-step CORDIC.
// Reset (synchronous, active low) empties the queue and the pipeline and
// loads the clamp registers with 50 and 256.
module normal_grid_vertex_light_core #(
    parameter int unsigned GRID_PITCH = ngvl_pkg::GRID_PITCH_DEF,
    parameter int unsigned GRID_YAW   = ngvl_pkg::GRID_YAW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  ngvl_pkg::t_s16                  i_norm_x,
    input  ngvl_pkg::t_s16                  i_norm_y,
    input  ngvl_pkg::t_s16                  i_norm_z,
    input  ngvl_pkg::t_s16                  i_light_dir_x,
    input  ngvl_pkg::t_s16                  i_light_dir_y,
    input  ngvl_pkg::t_s16                  i_light_dir_z,
    input  ngvl_pkg::t_s17                  i_pitch_offset,
    input  ngvl_pkg::t_s17                  i_yaw_offset,
    output logic                            empty,
    input  logic                            pop,
    output logic [16:0]                     o_light_factor,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [ngvl_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ngvl_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    logic [ngvl_pkg::CFG_DATA_W-1:0] r_light_floor;
    logic [ngvl_pkg::CFG_DATA_W-1:0] r_light_ceiling;

    logic                  w_q_full;
    logic                  w_q_wr;
    ngvl_pkg::t_front_item w_q_wdata;
    logic                  w_q_rd;
    ngvl_pkg::t_front_item w_q_rdata;
    logic                  w_q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_light_floor   <= ngvl_pkg::LIGHT_FLOOR_RST;
            r_light_ceiling <= ngvl_pkg::LIGHT_CEILING_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ngvl_pkg::CFG_LIGHT_FLOOR:   r_light_floor   <= i_cfg_data;
                ngvl_pkg::CFG_LIGHT_CEILING: r_light_ceiling <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ngvl_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_norm_x       (i_norm_x),
        .i_norm_y       (i_norm_y),
        .i_norm_z       (i_norm_z),
        .i_light_dir_x  (i_light_dir_x),
        .i_light_dir_y  (i_light_dir_y),
        .i_light_dir_z  (i_light_dir_z),
        .i_pitch_offset (i_pitch_offset),
        .i_yaw_offset   (i_yaw_offset),
        .i_q_full       (w_q_full),
        .o_q_wr         (w_q_wr),
        .o_q_data       (w_q_wdata)
    );

    ngvl_queue #(.DEPTH(ngvl_pkg::QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_data  (w_q_wdata),
        .o_full  (w_q_full),
        .i_rd    (w_q_rd),
        .o_data  (w_q_rdata),
        .o_empty (w_q_empty)
    );

    ngvl_back #(
        .GRID_PITCH (GRID_PITCH),
        .GRID_YAW   (GRID_YAW)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .o_q_rd          (w_q_rd),
        .i_q_data        (w_q_rdata),
        .i_light_floor   (r_light_floor),
        .i_light_ceiling (r_light_ceiling),
        .pop             (pop),
        .empty           (empty),
        .o_light_factor  (o_light_factor)
    );

endmodule

### rtl/core/ngvl_front.sv
// ----------------------------------------------------------------------------
// ngvl_front
// Input stage: takes a beat, flags a vertical normal and squares the
// horizontal normal components, then hands the item to the queue.
// ----------------------------------------------------------------------------
module ngvl_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  ngvl_pkg::t_s16        i_norm_x,
    input  ngvl_pkg::t_s16        i_norm_y,
    input  ngvl_pkg::t_s16        i_norm_z,
    input  ngvl_pkg::t_s16        i_light_dir_x,
    input  ngvl_pkg::t_s16        i_light_dir_y,
    input  ngvl_pkg::t_s16        i_light_dir_z,
    input  ngvl_pkg::t_s17        i_pitch_offset,
    input  ngvl_pkg::t_s17        i_yaw_offset,
    input  logic                  i_q_full,
    output logic                  o_q_wr,
    output ngvl_pkg::t_front_item o_q_data
);

    logic                  r_valid;
    ngvl_pkg::t_front_item r_item;
    logic signed [31:0]    w_sqx;
    logic signed [31:0]    w_sqy;
    logic                  w_load;

    assign w_sqx  = i_norm_x * i_norm_x;
    assign w_sqy  = i_norm_y * i_norm_y;
    assign full   = r_valid && i_q_full;
    assign w_load = push && !full;
    assign o_q_wr = r_valid && !i_q_full;
    assign o_q_data = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_q_wr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item.zero <= (i_norm_x == '0) && (i_norm_y == '0);
            r_item.nx   <= i_norm_x;
            r_item.ny   <= i_norm_y;
            r_item.nz   <= i_norm_z;
            r_item.dx   <= i_light_dir_x;
            r_item.dy   <= i_light_dir_y;
            r_item.dz   <= i_light_dir_z;
            r_item.po   <= i_pitch_offset;
            r_item.yo   <= i_yaw_offset;
            r_item.sqx  <= w_sqx[30:0];
            r_item.sqy  <= w_sqy[30:0];
        end
    end

endmodule

### rtl/core/ngvl_queue.sv
// ----------------------------------------------------------------------------
// ngvl_queue
// Short FIFO between the front and the back pipeline.
// ----------------------------------------------------------------------------
module ngvl_queue #(
    parameter int unsigned DEPTH = ngvl_pkg::QUEUE_DEPTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr,
    input  ngvl_pkg::t_front_item i_data,
    output logic                  o_full,
    input  logic                  i_rd,
    output ngvl_pkg::t_front_item o_data,
    output logic                  o_empty
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);

    ngvl_pkg::t_front_item r_mem [DEPTH];
    logic [PW-1:0]         r_wr_ptr;
    logic [PW-1:0]         r_rd_ptr;
    logic [CW-1:0]         r_count;
    logic                  w_wr;
    logic                  w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wr_ptr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### rtl/core/ngvl_grid_index.sv
// ----------------------------------------------------------------------------
// ngvl_grid_index
// Four-stage unit: angle sum * GRID / 360deg, truncated toward zero, then
// wrapped into 0..GRID-1. The divide uses a reciprocal multiply plus one
// correction step.
// ----------------------------------------------------------------------------
module ngvl_grid_index #(
    parameter  int unsigned GRID = ngvl_pkg::GRID_PITCH_DEF,
    localparam int unsigned IW   = $clog2(GRID)
) (
    input  logic               i_clk,
    input  logic               i_adv,
    input  logic signed [17:0] i_sum,
    output logic [IW-1:0]      o_index
);

    localparam int unsigned VW = 18 + $clog2(GRID);
    localparam int unsigned MW = VW - 1;
    localparam int unsigned QW = VW - 16;
    localparam int unsigned PW = MW + ngvl_pkg::RECIP_W;

    logic signed [VW-1:0] w_prod;
    logic [MW-1:0]        w_mag;
    logic [PW-1:0]        w_recip;
    logic [QW-1:0]        w_q1;
    logic [QW-1:0]        w_r;

    logic                 r_neg1;
    logic [MW-1:0]        r_mag1;
    logic                 r_neg2;
    logic [MW-1:0]        r_mag2;
    logic [QW-1:0]        r_q2;
    logic                 r_neg3;
    logic [QW-1:0]        r_q3;
    logic [MW-1:0]        r_rem3;

    assign w_prod  = VW'(i_sum) * $signed(VW'(GRID));
    assign w_mag   = w_prod[VW-1] ? MW'(-w_prod) : MW'(w_prod);
    assign w_recip = PW'(r_mag1) * PW'(ngvl_pkg::RECIP_360);

    // estimate is at most one short
    always_comb begin
        w_q1 = r_q3 + QW'(r_rem3 >= MW'(ngvl_pkg::DEG360_Q7));
        priority if (w_q1 >= QW'(2 * GRID)) begin
            w_r = w_q1 - QW'(2 * GRID);
        end else if (w_q1 >= QW'(GRID)) begin
            w_r = w_q1 - QW'(GRID);
        end else begin
            w_r = w_q1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_neg1  <= w_prod[VW-1];
            r_mag1  <= w_mag;
            r_neg2  <= r_neg1;
            r_mag2  <= r_mag1;
            r_q2    <= QW'(w_recip >> ngvl_pkg::RECIP_SHIFT);
            r_neg3  <= r_neg2;
            r_q3    <= r_q2;
            r_rem3  <= r_mag2 - MW'(r_q2) * MW'(ngvl_pkg::DEG360_Q7);
            o_index <= (r_neg3 && (w_r != '0)) ? IW'(QW'(GRID) - w_r) : IW'(w_r);
        end
    end

endmodule

### rtl/core/ngvl_back.sv
// ----------------------------------------------------------------------------
// ngvl_back
// Execution pipeline: magnitude square root and yaw CORDIC side by side,
// elevation CORDIC, fold, grid index, direction table, dot product, clamp.
// Every stage moves together; the last stage is the result register.
// ----------------------------------------------------------------------------
module ngvl_back #(
    parameter  int unsigned GRID_PITCH = ngvl_pkg::GRID_PITCH_DEF,
    parameter  int unsigned GRID_YAW   = ngvl_pkg::GRID_YAW_DEF,
    localparam int unsigned PIW        = $clog2(GRID_PITCH),
    localparam int unsigned YIW        = $clog2(GRID_YAW)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    output logic                              o_q_rd,
    input  ngvl_pkg::t_front_item             i_q_data,
    input  logic [ngvl_pkg::CFG_DATA_W-1:0]   i_light_floor,
    input  logic [ngvl_pkg::CFG_DATA_W-1:0]   i_light_ceiling,
    input  logic                              pop,
    output logic                              empty,
    output logic [16:0]                       o_light_factor
);

    localparam int unsigned NA = ngvl_pkg::SQRT_STEPS;
    localparam int unsigned NB = ngvl_pkg::CORDIC_STEPS;
    localparam int unsigned NG = 4;

    typedef struct packed {
        ngvl_pkg::t_ang x;
        ngvl_pkg::t_ang y;
        ngvl_pkg::t_ang z;
    } t_vec;

    typedef struct packed {
        ngvl_pkg::t_s16 dx;
        ngvl_pkg::t_s16 dy;
        ngvl_pkg::t_s16 dz;
    } t_dir;

    typedef struct packed {
        logic           zero;
        logic           nz_pos;
        ngvl_pkg::t_s16 nz;
        t_dir           d;
        ngvl_pkg::t_s17 po;
        ngvl_pkg::t_s17 yo;
        logic [47:0]    n;
        logic [26:0]    rem;
        logic [23:0]    root;
        t_vec           yv;
    } t_a_item;

    typedef struct packed {
        logic           zero;
        logic           nz_pos;
        t_dir           d;
        ngvl_pkg::t_s17 po;
        ngvl_pkg::t_s17 yo;
        ngvl_pkg::t_ang yaw_z;
        t_vec           ev;
    } t_b_item;

    function automatic t_vec vec_step(t_vec v, int unsigned k);
        t_vec           o;
        ngvl_pkg::t_ang xs;
        ngvl_pkg::t_ang ys;
        ngvl_pkg::t_ang at;
        o  = v;
        xs = v.x >>> k;
        ys = v.y >>> k;
        at = ngvl_pkg::t_ang'(ngvl_pkg::ATAN_DEG_Q16[k[ngvl_pkg::CORDIC_IDX_W-1:0]]);
        if (!v.y[26] && (v.y != '0)) begin
            o.x = v.x + ys;
            o.y = v.y - xs;
            o.z = v.z + at;
        end else if (v.y[26]) begin
            o.x = v.x - ys;
            o.y = v.y + xs;
            o.z = v.z - at;
        end
        return o;
    endfunction

    // one root bit per stage, yaw rotation during the first CORDIC_STEPS
    function automatic t_a_item a_step(t_a_item v, int unsigned k);
        t_a_item     o;
        logic [26:0] rem2;
        logic [26:0] trial;
        o     = v;
        rem2  = {v.rem[24:0], v.n[47:46]};
        trial = {1'b0, v.root, 2'b01};
        if (rem2 >= trial) begin
            o.rem  = rem2 - trial;
            o.root = {v.root[22:0], 1'b1};
        end else begin
            o.rem  = rem2;
            o.root = {v.root[22:0], 1'b0};
        end
        o.n = {v.n[45:0], 2'b00};
        if (k < ngvl_pkg::CORDIC_STEPS) o.yv = vec_step(v.yv, k);
        return o;
    endfunction

    function automatic t_b_item b_step(t_b_item v, int unsigned k);
        t_b_item o;
        o    = v;
        o.ev = vec_step(v.ev, k);
        return o;
    endfunction

    function automatic logic [15:0] fold_q7(ngvl_pkg::t_ang z);
        ngvl_pkg::t_ang     t;
        logic signed [17:0] a;
        t = z + 27'sd256;
        a = t[26:9];
        priority if (a[17]) begin
            a = a + 18'sd46080;
        end else if (a >= 18'sd46080) begin
            a = a - 18'sd46080;
        end
        return a[15:0];
    endfunction

    logic    w_adv;
    t_a_item w_a0;
    t_b_item w_b0;
    ngvl_pkg::t_ang w_x0;
    ngvl_pkg::t_ang w_y0;
    logic [31:0] w_mag2;

    t_a_item r_a  [NA+1];
    logic    r_av [NA+1];
    t_b_item r_b  [1:NB];
    logic    r_bv [1:NB];

    assign w_adv  = empty || pop;
    assign o_q_rd = w_adv && !i_q_empty;

    // ---- entry from the queue
    always_comb begin
        w_x0   = ngvl_pkg::t_ang'(i_q_data.nx) <<< 8;
        w_y0   = ngvl_pkg::t_ang'(i_q_data.ny) <<< 8;
        w_mag2 = 32'(i_q_data.sqx) + 32'(i_q_data.sqy);
        w_a0.zero   = i_q_data.zero;
        w_a0.nz_pos = !i_q_data.nz[15] && (i_q_data.nz != '0);
        w_a0.nz     = i_q_data.nz;
        w_a0.d.dx   = i_q_data.dx;
        w_a0.d.dy   = i_q_data.dy;
        w_a0.d.dz   = i_q_data.dz;
        w_a0.po     = i_q_data.po;
        w_a0.yo     = i_q_data.yo;
        w_a0.n      = {w_mag2, 16'b0};
        w_a0.rem    = '0;
        w_a0.root   = '0;
        if (w_x0[26]) begin
            w_a0.yv.x = -w_x0;
            w_a0.yv.y = -w_y0;
            w_a0.yv.z = ngvl_pkg::t_ang'(ngvl_pkg::DEG180_Q16);
        end else begin
            w_a0.yv.x = w_x0;
            w_a0.yv.y = w_y0;
            w_a0.yv.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) r_a[0] <= w_a0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av[0] <= 1'b0;
        end else if (w_adv) begin
            r_av[0] <= o_q_rd;
        end
    end

    // ---- square root and yaw angle
    for (genvar k = 0; k < NA; k++) begin : g_a
        always_ff @(posedge i_clk) begin
            if (w_adv) r_a[k+1] <= a_step(r_a[k], k);
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[k+1] <= 1'b0;
            end else if (w_adv) begin
                r_av[k+1] <= r_av[k];
            end
        end
    end

    // ---- elevation angle from (magnitude, nz)
    always_comb begin
        w_b0.zero   = r_a[NA].zero;
        w_b0.nz_pos = r_a[NA].nz_pos;
        w_b0.d      = r_a[NA].d;
        w_b0.po     = r_a[NA].po;
        w_b0.yo     = r_a[NA].yo;
        w_b0.yaw_z  = r_a[NA].yv.z;
        w_b0.ev.x   = ngvl_pkg::t_ang'({3'b000, r_a[NA].root});
        w_b0.ev.y   = ngvl_pkg::t_ang'(r_a[NA].nz) <<< 8;
        w_b0.ev.z   = '0;
    end

    for (genvar k = 0; k < NB; k++) begin : g_b
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (w_adv) r_b[1] <= b_step(w_b0, k);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_bv[1] <= 1'b0;
                end else if (w_adv) begin
                    r_bv[1] <= r_av[NA];
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (w_adv) r_b[k+1] <= b_step(r_b[k], k);
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_bv[k+1] <= 1'b0;
                end else if (w_adv) begin
                    r_bv[k+1] <= r_bv[k];
                end
            end
        end
    end

    // ---- fold both angles
    logic        r_fv;
    logic [15:0] r_f_elev;
    logic [15:0] r_f_yaw;
    t_dir        r_f_d;
    ngvl_pkg::t_s17 r_f_po;
    ngvl_pkg::t_s17 r_f_yo;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            if (r_b[NB].zero) begin
                r_f_yaw  <= '0;
                r_f_elev <= r_b[NB].nz_pos ? 16'(ngvl_pkg::DEG90_Q7)
                                           : 16'(ngvl_pkg::DEG270_Q7);
            end else begin
                r_f_yaw  <= fold_q7(r_b[NB].yaw_z);
                r_f_elev <= fold_q7(r_b[NB].ev.z);
            end
            r_f_d  <= r_b[NB].d;
            r_f_po <= r_b[NB].po;
            r_f_yo <= r_b[NB].yo;
        end
    end

    // ---- grid indices
    logic signed [17:0] w_sum_p;
    logic signed [17:0] w_sum_y;
    logic [PIW-1:0]     w_pi;
    logic [YIW-1:0]     w_yi;
    t_dir               r_g_d  [1:NG];
    logic               r_gv   [1:NG];

    assign w_sum_p = $signed({2'b00, r_f_elev}) + {r_f_po[16], r_f_po};
    assign w_sum_y = $signed({2'b00, r_f_yaw}) + {r_f_yo[16], r_f_yo}
                   + 18'(ngvl_pkg::DEG90_Q7);

    ngvl_grid_index #(.GRID(GRID_PITCH)) u_pitch_idx (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_sum   (w_sum_p),
        .o_index (w_pi)
    );

    ngvl_grid_index #(.GRID(GRID_YAW)) u_yaw_idx (
        .i_clk   (i_clk),
        .i_adv   (w_adv),
        .i_sum   (w_sum_y),
        .o_index (w_yi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (w_adv) begin
            r_fv <= r_bv[NB];
        end
    end

    for (genvar k = 0; k < NG; k++) begin : g_gd
        if (k == 0) begin : g_head
            always_ff @(posedge i_clk) begin
                if (w_adv) r_g_d[1] <= r_f_d;
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_gv[1] <= 1'b0;
                end else if (w_adv) begin
                    r_gv[1] <= r_fv;
                end
            end
        end else begin : g_tail
            always_ff @(posedge i_clk) begin
                if (w_adv) r_g_d[k+1] <= r_g_d[k];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_gv[k+1] <= 1'b0;
                end else if (w_adv) begin
                    r_gv[k+1] <= r_gv[k];
                end
            end
        end
    end

    // ---- direction tables (pitch gives cy/sy, yaw gives cp/sp)
    ngvl_pkg::t_sc w_tab_p [GRID_PITCH];
    ngvl_pkg::t_sc w_tab_y [GRID_YAW];

    for (genvar p = 0; p < GRID_PITCH; p++) begin : g_tab_p
        localparam ngvl_pkg::t_sc SC = ngvl_pkg::sin_cos_deg(p * 360 / GRID_PITCH);
        assign w_tab_p[p] = SC;
    end

    for (genvar q = 0; q < GRID_YAW; q++) begin : g_tab_y
        localparam ngvl_pkg::t_sc SC = ngvl_pkg::sin_cos_deg(q * 360 / GRID_YAW);
        assign w_tab_y[q] = SC;
    end

    logic           r_tv;
    ngvl_pkg::t_sc  r_t_pit;
    ngvl_pkg::t_sc  r_t_yaw;
    t_dir           r_t_d;

    logic               r_pv;
    logic signed [31:0] r_p_cc;
    logic signed [31:0] r_p_cs;
    ngvl_pkg::t_s16     r_p_sp;
    t_dir               r_p_d;

    logic signed [31:0] w_g0;
    logic signed [31:0] w_g1;
    logic signed [16:0] w_g2;

    logic               r_mv;
    logic signed [32:0] r_m0;
    logic signed [32:0] r_m1;
    logic signed [32:0] r_m2;

    logic               r_sv;
    logic signed [34:0] r_dot;

    logic signed [37:0] w_lt;
    logic signed [22:0] w_li;
    logic signed [22:0] w_ceil;
    logic signed [22:0] w_floor;
    logic signed [22:0] w_cl;

    assign w_g0 = (r_p_cc + 32'sd8192) >>> 14;
    assign w_g1 = (r_p_cs + 32'sd8192) >>> 14;
    assign w_g2 = -17'(r_p_sp);

    // (dot + 2) * 1.5 in Q8, round half up, ceiling first then floor
    always_comb begin
        w_lt    = (38'(r_dot) + 38'sd8388608) * 38'sd3 + 38'sd16384;
        w_li    = w_lt[37:15];
        w_ceil  = $signed({6'b0, i_light_ceiling, 8'b0});
        w_floor = $signed({6'b0, i_light_floor, 8'b0});
        w_cl    = (w_li > w_ceil) ? w_ceil : w_li;
        if (w_cl < w_floor) w_cl = w_floor;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t_pit <= w_tab_p[w_pi];
            r_t_yaw <= w_tab_y[w_yi];
            r_t_d   <= r_g_d[NG];

            r_p_cc  <= r_t_yaw.c * r_t_pit.c;
            r_p_cs  <= r_t_yaw.c * r_t_pit.s;
            r_p_sp  <= r_t_yaw.s;
            r_p_d   <= r_t_d;

            r_m0    <= 17'(w_g0) * r_p_d.dx;
            r_m1    <= 17'(w_g1) * r_p_d.dy;
            r_m2    <= w_g2 * r_p_d.dz;

            r_dot   <= 35'(r_m0) + 35'(r_m1) + 35'(r_m2);

            o_light_factor <= w_cl[16:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tv  <= 1'b0;
            r_pv  <= 1'b0;
            r_mv  <= 1'b0;
            r_sv  <= 1'b0;
            empty <= 1'b1;
        end else if (w_adv) begin
            r_tv  <= r_gv[NG];
            r_pv  <= r_tv;
            r_mv  <= r_pv;
            r_sv  <= r_mv;
            empty <= !r_sv;
        end
    end

endmodule

### rtl/core/ngvl_checker.sv
// ----------------------------------------------------------------------------
// ngvl_checker
// Port-level checks for the normal grid vertex light core.
// ----------------------------------------------------------------------------
module ngvl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [16:0] o_light_factor
);

    // reset drains the result side
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result pending after reset");

    // reset frees the input side
    a_rst_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("input blocked after reset");

    // a waiting result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_light_factor)))
        else $error("waiting result changed");

    // clamp keeps the factor at or below 511 light units
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_light_factor <= 17'd130816))
        else $error("light factor out of range");

endmodule

bind normal_grid_vertex_light_core ngvl_checker u_ngvl_checker (.*);

### tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives vertices into normal_grid_vertex_light_core through its push/full
// port and checks each popped light factor against a bit-exact CORDIC light
// calculator, under random bursts, pop stalls and several clamp settings.
// ----------------------------------------------------------------------------
module tb;

    localparam int     GRID_P = 64;
    localparam int     GRID_Y = 64;
    localparam longint ARC_Q16 [16] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115
    };
    // register indexes with no register behind them
    localparam logic [ngvl_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [ngvl_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        ngvl_pkg::t_s16 nx, ny, nz, dx, dy, dz;
        ngvl_pkg::t_s17 po, yo;
    } t_vertex;

    typedef struct {
        t_vertex     v;
        logic        typed;
        logic [16:0] light;
    } t_vec_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        pop = 1'b0;
    logic        full, empty, o_cfg_ready;
    ngvl_pkg::t_s16 i_norm_x = '0, i_norm_y = '0, i_norm_z = '0;
    ngvl_pkg::t_s16 i_light_dir_x = '0, i_light_dir_y = '0, i_light_dir_z = '0;
    ngvl_pkg::t_s17 i_pitch_offset = '0, i_yaw_offset = '0;
    logic [16:0] o_light_factor;
    logic        i_cfg_valid = 1'b0;
    logic [ngvl_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ngvl_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    logic [16:0] light_due[$];
    int          errors = 0;
    int          burst_left = 0;
    logic [8:0]  floor_reg, ceil_reg;

    normal_grid_vertex_light_core dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // atan2(y, x) in degrees Q16 by vectoring
    function automatic longint vec_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 180 * 65536;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ARC_Q16[i];
            end else if (y < 0) begin
                x -= ys; y += xs; z -= ARC_Q16[i];
            end
        end
        return z;
    endfunction

    function automatic longint fold_deg(longint z16);
        longint a;
        a = (z16 + 256) >>> 9;
        while (a < 0) a += ngvl_pkg::DEG360_Q7;
        while (a >= ngvl_pkg::DEG360_Q7) a -= ngvl_pkg::DEG360_Q7;
        return a;
    endfunction

    function automatic longint root64(longint unsigned n);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic void trig_deg(input longint deg, output longint c, output longint s);
        longint a, x, y, z, xs, ys;
        logic   flip;
        a = deg;
        x = 39797 * 256;
        y = 0;
        flip = 1'b0;
        if (a > 180) a -= 360;
        if (a > 90) begin
            a -= 180; flip = 1'b1;
        end else if (a < -90) begin
            a += 180; flip = 1'b1;
        end
        z = a * 65536;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ARC_Q16[i];
            end else begin
                x += ys; y -= xs; z += ARC_Q16[i];
            end
        end
        c = (x + 512) >>> 10;
        s = (y + 512) >>> 10;
        if (flip) begin
            c = -c; s = -s;
        end
    endfunction

    function automatic longint cell_of(longint sum, longint size);
        longint r;
        r = (sum * size / ngvl_pkg::DEG360_Q7) % size;
        if (r < 0) r += size;
        return r;
    endfunction

    function automatic logic [16:0] calc_light(t_vertex v);
        longint nx, ny, nz, yaw, elev, pi, yi, cy, sy, cp, sp, gx, gy, gz, dot, lt;
        nx = v.nx; ny = v.ny; nz = v.nz;
        if (nx == 0 && ny == 0) begin
            yaw  = 0;
            elev = nz > 0 ? ngvl_pkg::DEG90_Q7 : ngvl_pkg::DEG270_Q7;
        end else begin
            yaw  = fold_deg(vec_angle(nx * 256, ny * 256));
            elev = fold_deg(vec_angle(root64(longint'(nx * nx + ny * ny) << 16), nz * 256));
        end
        pi = cell_of(elev + longint'(v.po), GRID_P);
        yi = cell_of(yaw + longint'(v.yo) + ngvl_pkg::DEG90_Q7, GRID_Y);
        trig_deg(pi * 360 / GRID_P, cy, sy);
        trig_deg(yi * 360 / GRID_Y, cp, sp);
        gx = (cp * cy + 8192) >>> 14;
        gy = (cp * sy + 8192) >>> 14;
        gz = -sp;
        dot = gx * longint'(v.dx) + gy * longint'(v.dy) + gz * longint'(v.dz);
        lt = ((dot + (longint'(2) << 22)) * 3 + (longint'(1) << 14)) >>> 15;
        if (lt > longint'(ceil_reg) * 256) lt = longint'(ceil_reg) * 256;
        if (lt < longint'(floor_reg) * 256) lt = longint'(floor_reg) * 256;
        return 17'(lt);
    endfunction

    // bursts with random gaps; expectation recorded at the accepting edge
    task automatic send_vertex(t_vertex v, logic typed, logic [16:0] light);
        if (burst_left == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 150 : $urandom_range(1, 20);
        end
        push           <= 1'b1;
        i_norm_x       <= v.nx;
        i_norm_y       <= v.ny;
        i_norm_z       <= v.nz;
        i_light_dir_x  <= v.dx;
        i_light_dir_y  <= v.dy;
        i_light_dir_z  <= v.dz;
        i_pitch_offset <= v.po;
        i_yaw_offset   <= v.yo;
        do @(posedge i_clk); while (full);
        light_due.push_back(typed ? light : calc_light(v));
        burst_left--;
    endtask

    task automatic drain();
        push <= 1'b0;
        burst_left = 0;
        while (light_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [ngvl_pkg::CFG_IDX_W-1:0] idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == ngvl_pkg::CFG_LIGHT_FLOOR) floor_reg = data;
        else if (idx == ngvl_pkg::CFG_LIGHT_CEILING) ceil_reg = data;
    endtask

    function automatic t_vertex rand_vertex();
        t_vertex v;
        int      kind;
        kind = $urandom_range(0, 9);
        v.dx = ngvl_pkg::t_s16'($urandom);
        v.dy = ngvl_pkg::t_s16'($urandom);
        v.dz = ngvl_pkg::t_s16'($urandom);
        if (kind == 0) begin
            v.nx = ngvl_pkg::t_s16'($urandom);
            v.ny = ngvl_pkg::t_s16'($urandom);
            v.nz = ngvl_pkg::t_s16'($urandom);
            v.po = ngvl_pkg::t_s17'($urandom);
            v.yo = ngvl_pkg::t_s17'($urandom);
        end else begin
            v.nx = ngvl_pkg::t_s16'(int'($urandom_range(0, 32768)) - 16384);
            v.ny = ngvl_pkg::t_s16'(int'($urandom_range(0, 32768)) - 16384);
            v.nz = ngvl_pkg::t_s16'(int'($urandom_range(0, 32768)) - 16384);
            if (kind == 1) begin
                v.nx = '0; v.ny = '0;
            end
            v.po = ngvl_pkg::t_s17'(int'($urandom_range(0, 92159)) - 46080);
            v.yo = ngvl_pkg::t_s17'(int'($urandom_range(0, 92159)) - 46080);
        end
        return v;
    endfunction

    // receiver: pop rate changes during the run
    int pop_pct = 100;
    int pop_tick = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (light_due.size() == 0) begin
                report_mismatch("unexpected light_factor", o_light_factor, -1);
            end else begin
                if (o_light_factor !== light_due[0])
                    report_mismatch("light_factor", o_light_factor, light_due[0]);
                void'(light_due.pop_front());
            end
        end
        pop_tick <= pop_tick + 1;
        if (pop_tick % 97 == 0) begin
            case ($urandom_range(0, 3))
                0: pop_pct = 100;
                1: pop_pct = 70;
                2: pop_pct = 30;
                default: pop_pct = 5;
            endcase
        end
        pop <= ($urandom_range(0, 99) < pop_pct);
    end

    t_vec_row rows[] = '{
        // zero light direction: dot 0, light 768 lifts to floor 50
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0}, 1'b1, 17'd12800},
        '{'{16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 17'sd0, 17'sd0},
          1'b1, 17'd12800},
        '{'{16'sd0, 16'sd0, -16'sd16384, 16'sd256, 16'sd0, 16'sd0, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd256, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{16'sd16384, 16'sd0, 16'sd0, 16'sd256, 16'sd256, 16'sd256, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{-16'sd16384, 16'sd0, 16'sd0, -16'sd256, 16'sd0, 16'sd0, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{16'sd0, 16'sd16384, 16'sd0, 16'sd0, 16'sd256, 16'sd0, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{16'sd0, -16'sd16384, 16'sd0, 16'sd0, -16'sd256, 16'sd0, 17'sd0, 17'sd0}, 1'b0, 0},
        '{'{16'sd16384, 16'sd16384, 16'sd16384, 16'sd32767, 16'sd32767, 16'sd32767,
            17'sd46079, 17'sd46079}, 1'b0, 0},
        '{'{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd32768, -16'sd32768, -16'sd32768,
            -17'sd46080, -17'sd46080}, 1'b0, 0},
        '{'{16'sd32767, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'sd0,
            17'sd65535, -17'sd65536}, 1'b0, 0},
        '{'{-16'sd32768, 16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767, 16'sd1,
            -17'sd65536, 17'sd65535}, 1'b0, 0},
        '{'{16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd32768, 17'sd11520, 17'sd0}, 1'b0, 0},
        '{'{-16'sd1, -16'sd1, 16'sd0, 16'sd1000, -16'sd1000, 16'sd5, -17'sd1, 17'sd1},
          1'b0, 0},
        '{'{16'sd11585, 16'sd11585, 16'sd0, 16'sd181, 16'sd181, 16'sd0, 17'sd0, -17'sd11520},
          1'b0, 0}
    };

    logic [8:0] floors[] = '{9'd0, 9'd511, 9'd0, 9'd511, 9'd100, 9'd50};
    logic [8:0] ceils[]  = '{9'd511, 9'd0, 9'd0, 9'd511, 9'd300, 9'd256};

    initial begin
        floor_reg = ngvl_pkg::LIGHT_FLOOR_RST;
        ceil_reg  = ngvl_pkg::LIGHT_CEILING_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) send_vertex(rows[i].v, rows[i].typed, rows[i].light);
        drain();
        // unknown indexes must be ignored
        write_reg(CFG_SPARE_A, 9'h1FF);
        write_reg(CFG_SPARE_B, 9'h000);
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(ngvl_pkg::CFG_LIGHT_FLOOR, ph == 4 ? 9'($urandom) : floors[ph]);
            write_reg(ngvl_pkg::CFG_LIGHT_CEILING, ph == 4 ? 9'($urandom) : ceils[ph]);
            for (int n = 0; n < 165; n++) begin
                if (ph == 2 && n == 80) drain();
                send_vertex(rand_vertex(), 1'b0, '0);
            end
            drain();
        end
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
